// File: hw/rtl/text_line_wrap_align_defines.svh
// ----------------------------------------------------------------------------
// text line wrap and align - assertion macros
// concurrent checks on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_WRAP_ALIGN_DEFINES_SVH
`define TEXT_LINE_WRAP_ALIGN_DEFINES_SVH

`ifndef ASSERT_OFF
`define TLWA_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define TLWA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TLWA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TLWA_ASSERT(label, expr, msg)
`define TLWA_ASSERT_IMPL(label, ante, cons, msg)
`define TLWA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: hw/rtl/tlwa_pkg.sv
// ----------------------------------------------------------------------------
// text line wrap and align - package
// request and result payload types, register indexes, align modes and character codes
// ----------------------------------------------------------------------------
package tlwa_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       text_end;
  } tlwa_in_t;

  typedef struct packed {
    logic [7:0]         glyph_index;
    logic signed [15:0] x_offset;
    logic signed [15:0] y_offset;
    logic               line_last;
    logic               chars_dropped;
  } tlwa_out_t;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_BOX_WIDTH    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_WIDTH  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHAR_SPACING = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_ADVANCE = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_CODE   = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_COUNT   = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_WRAP_ENABLE  = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_ALIGN_MODE   = 4'd7;

  localparam logic [1:0] ALIGN_LEFT   = 2'd0;
  localparam logic [1:0] ALIGN_CENTER = 2'd1;
  localparam logic [1:0] ALIGN_RIGHT  = 2'd2;

  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

endpackage

// File: hw/rtl/tlwa_chan_if.sv
// ----------------------------------------------------------------------------
// text line wrap and align - request channel
// valid/ready channel carrying one payload of a given type
// ----------------------------------------------------------------------------
interface tlwa_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/text_line_wrap_align.sv
// ----------------------------------------------------------------------------
// text line wrap and align - top level
// buffers glyphs of one line, breaks lines and emits aligned glyph offsets
// ----------------------------------------------------------------------------
// a byte passes the decide state and, unless it is a newline, the place
// state before ready is raised again; each line end walks the line start
// state, a read and a load state per buffered glyph and the line done state,
// paced by the registered line buffer read and the shared adder; results
// are registered at each load, and output stalls hold the load state
// reset (synchronous) restores the register defaults and empties the line;
// the line buffer itself is not cleared
// ----------------------------------------------------------------------------
`include "text_line_wrap_align_defines.svh"

module text_line_wrap_align
  import tlwa_pkg::*;
#(
  parameter int unsigned LINE_CHARS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  tlwa_chan_if.sink              text_in,
  tlwa_chan_if.source            glyph_out
);

  localparam int unsigned CW = $clog2(LINE_CHARS + 1);
  localparam int unsigned IW = $clog2(LINE_CHARS);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_PLACE  = 7'b0000100,
    S_LSTART = 7'b0001000,
    S_LREAD  = 7'b0010000,
    S_LLOAD  = 7'b0100000,
    S_LDONE  = 7'b1000000
  } state_t;

  state_t state;

  logic [11:0] box_width;
  logic [7:0]  glyph_width;
  logic [7:0]  char_spacing;
  logic [8:0]  line_advance;
  logic [7:0]  first_code;
  logic [7:0]  code_count;
  logic        wrap_enable;
  logic [1:0]  align_mode;

  logic [7:0]  cur_code;
  logic        cur_fin;
  logic        place_pend;
  logic        fin_pend;

  logic [7:0]  line_glyphs [LINE_CHARS];
  logic [7:0]  rd_data;
  logic [CW-1:0] glyph_count;
  logic [CW-1:0] k;
  logic [15:0] raw_line_width;
  logic [15:0] line_top;
  logic        overflow_seen;
  logic [15:0] x_acc;

  tlwa_out_t   out_data;
  logic        out_valid;

  logic [7:0]  code_last;
  logic        is_nl;
  logic        visible;
  logic        wrap_hit;
  logic        room;
  logic [8:0]  pitch;
  logic [15:0] add_a;
  logic [15:0] add_b;
  logic [15:0] add_sum;
  logic signed [17:0] line_w;
  logic signed [17:0] diff;
  logic signed [17:0] half;
  logic signed [17:0] off;
  logic [CW-1:0] k_inc;
  logic        load;
  logic        in_fire;

  assign text_in.ready   = (state == S_IDLE);
  assign in_fire         = text_in.valid && text_in.ready;
  assign glyph_out.valid = out_valid;
  assign glyph_out.data  = out_data;

  // decode of the held byte
  assign code_last = first_code + code_count;
  assign is_nl     = (cur_code == CHAR_NL);
  assign visible   = (cur_code != CHAR_CR) && (cur_code >= first_code) &&
                     (cur_code < code_last);
  assign wrap_hit  = wrap_enable && (glyph_count != '0) &&
                     (({1'b0, raw_line_width} + {9'd0, glyph_width}) >
                      {5'd0, box_width});
  assign room      = (glyph_count < CW'(LINE_CHARS));
  assign pitch     = {1'b0, glyph_width} + {1'b0, char_spacing};

  // shared adder
  always_comb begin
    add_a = x_acc;
    add_b = {7'd0, pitch};
    unique case (state)
      S_PLACE: add_a = raw_line_width;
      S_LDONE: begin
        add_a = line_top;
        add_b = {7'd0, line_advance};
      end
      default: add_a = x_acc;
    endcase
  end
  assign add_sum = add_a + add_b;

  // line offset
  always_comb begin
    line_w = '0;
    if (glyph_count != '0) begin
      line_w = $signed({2'b00, raw_line_width}) - $signed({10'd0, char_spacing});
    end
    diff = $signed({6'd0, box_width}) - line_w;
    half = (diff + $signed({17'd0, diff[17]})) >>> 1;
    case (align_mode)
      ALIGN_CENTER: off = half;
      ALIGN_RIGHT:  off = diff;
      default:      off = '0;
    endcase
  end

  assign k_inc = k + CW'(1);
  assign load  = (state == S_LLOAD) && (!out_valid || glyph_out.ready);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      box_width    <= 12'd128;
      glyph_width  <= 8'd5;
      char_spacing <= 8'd1;
      line_advance <= 9'd8;
      first_code   <= 8'd32;
      code_count   <= 8'd95;
      wrap_enable  <= 1'b1;
      align_mode   <= ALIGN_LEFT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_WIDTH:    box_width    <= cfg_data[11:0];
        REG_GLYPH_WIDTH:  glyph_width  <= cfg_data[7:0];
        REG_CHAR_SPACING: char_spacing <= cfg_data[7:0];
        REG_LINE_ADVANCE: line_advance <= cfg_data[8:0];
        REG_FIRST_CODE:   first_code   <= cfg_data[7:0];
        REG_CODE_COUNT:   code_count   <= cfg_data[7:0];
        REG_WRAP_ENABLE:  wrap_enable  <= cfg_data[0];
        REG_ALIGN_MODE:   align_mode   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // line buffer
  always_ff @(posedge clk) begin
    if ((state == S_PLACE) && place_pend && room) begin
      line_glyphs[glyph_count[IW-1:0]] <= cur_code - first_code;
    end
    rd_data <= line_glyphs[k[IW-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      place_pend     <= 1'b0;
      fin_pend       <= 1'b0;
      glyph_count    <= '0;
      k              <= '0;
      raw_line_width <= '0;
      line_top       <= '0;
      overflow_seen  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            cur_code <= text_in.data.char_code;
            cur_fin  <= text_in.data.text_end;
            state    <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          place_pend <= !is_nl && visible;
          fin_pend   <= !is_nl && cur_fin;
          if (is_nl || (visible && wrap_hit)) begin
            state <= S_LSTART;
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (place_pend) begin
            if (room) begin
              glyph_count    <= glyph_count + CW'(1);
              raw_line_width <= add_sum;
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          place_pend <= 1'b0;
          if (fin_pend) begin
            fin_pend <= 1'b0;
            state    <= S_LSTART;
          end else begin
            state <= S_IDLE;
          end
        end
        S_LSTART: begin
          x_acc <= off[15:0];
          k     <= '0;
          if (glyph_count == '0) begin
            state <= S_LDONE;
          end else begin
            state <= S_LREAD;
          end
        end
        S_LREAD: begin
          state <= S_LLOAD;
        end
        S_LLOAD: begin
          if (load) begin
            x_acc <= add_sum;
            k     <= k_inc;
            if (k_inc == glyph_count) begin
              state <= S_LDONE;
            end else begin
              state <= S_LREAD;
            end
          end
        end
        S_LDONE: begin
          line_top       <= add_sum;
          glyph_count    <= '0;
          raw_line_width <= '0;
          overflow_seen  <= 1'b0;
          if (place_pend) begin
            state <= S_PLACE;
          end else if (fin_pend) begin
            fin_pend <= 1'b0;
            state    <= S_LSTART;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (glyph_out.ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      out_data.glyph_index   <= rd_data;
      out_data.x_offset      <= $signed(x_acc);
      out_data.y_offset      <= $signed(line_top);
      out_data.line_last     <= (k_inc == glyph_count) && !(place_pend && fin_pend);
      out_data.chars_dropped <= overflow_seen;
    end
  end

  `TLWA_ASSERT(a_count_bound, glyph_count <= CW'(LINE_CHARS), "glyph count past buffer depth")
  `TLWA_ASSERT_NEXT(a_accept_decide, in_fire, state == S_DECIDE, "accepted byte not decoded")
  `TLWA_ASSERT_IMPL(a_read_in_line, state == S_LREAD, k < glyph_count, "read beyond line end")
  `TLWA_ASSERT_IMPL(a_idle_clean, state == S_IDLE, !place_pend && !fin_pend, "pending work at idle")

endmodule

// File: bench/tb_text_line_wrap_align.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text line wrap and align - testbench
// drives text bytes through bursty requests into a stalling glyph sink and
// checks every glyph against a line-breaking predictor kept in step with the
// registers; a short directed table covers the corner cases, then random text
// runs over several register settings, extremes included
// ----------------------------------------------------------------------------
module tb_text_line_wrap_align;
  import tlwa_pkg::*;

  localparam int LINE_CHARS = 32;
  localparam int TEXT_TARGET = 410;
  localparam int PHASE_TEXT = 45;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 500;
  localparam int LIMIT_CYCLES = 600000;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 4'd8;
  localparam logic [1:0] ALIGN_SPARE = 2'd3;

  typedef enum int {FLOW_FREE, FLOW_HALF, FLOW_SPARSE, FLOW_MOSTLY} flow_t;

  typedef struct {
    bit                    is_reg;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic [7:0]            code;
    logic                  fin;
    int                    glyphs;
    logic [7:0]            idx;
    logic [15:0]           x;
    logic [15:0]           y;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tlwa_chan_if #(.payload_t(tlwa_in_t)) text_ch ();
  tlwa_chan_if #(.payload_t(tlwa_out_t)) glyph_ch ();

  text_line_wrap_align #(.LINE_CHARS(LINE_CHARS)) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .text_in(text_ch),
    .glyph_out(glyph_ch)
  );

  // register shadow
  logic [11:0] box_w;
  logic [7:0] glyph_w;
  logic [7:0] spacing;
  logic [8:0] advance;
  logic [7:0] first_code;
  logic [7:0] code_count;
  logic wrap_on;
  logic [1:0] align;

  // line state
  logic [7:0] line_buf [LINE_CHARS];
  int unsigned buf_count;
  logic [15:0] line_px;
  logic [15:0] top_y;
  logic dropped;

  tlwa_out_t step_glyphs[$];
  tlwa_out_t pending_glyphs[$];
  plan_row_t plan[$];

  int errors = 0;
  int burst_left = 0;
  int bytes_sent = 0;
  int text_items = 0;
  int glyphs_checked = 0;
  int lines_seen = 0;
  int dropped_seen = 0;
  int settings = 1;
  int cycles = 0;
  bit hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_model();
    box_w = 12'd128;
    glyph_w = 8'd5;
    spacing = 8'd1;
    advance = 9'd8;
    first_code = 8'd32;
    code_count = 8'd95;
    wrap_on = 1'b1;
    align = ALIGN_LEFT;
    buf_count = 0;
    line_px = '0;
    top_y = '0;
    dropped = 1'b0;
  endfunction

  function automatic void flush_line();
    int width;
    int off;
    int k;
    tlwa_out_t g;
    width = 0;
    off = 0;
    if (buf_count > 0) width = int'(line_px) - int'(spacing);
    if (align == ALIGN_CENTER) off = (int'(box_w) - width) / 2;
    else if (align == ALIGN_RIGHT) off = int'(box_w) - width;
    for (k = 0; k < int'(buf_count); k++) begin
      g.glyph_index = line_buf[k];
      g.x_offset = 16'(off + k * (int'(glyph_w) + int'(spacing)));
      g.y_offset = top_y;
      g.line_last = 1'b0;
      g.chars_dropped = dropped;
      step_glyphs.push_back(g);
    end
    top_y = top_y + 16'(advance);
    buf_count = 0;
    line_px = '0;
    dropped = 1'b0;
  endfunction

  // returns 1 when the byte is not simply skipped
  function automatic bit place_text(logic [7:0] c, logic fin);
    logic [7:0] stop;
    bit shown;
    tlwa_out_t g;
    step_glyphs.delete();
    stop = first_code + code_count;
    shown = (c != CHAR_CR) && (c >= first_code) && (c < stop);
    if (c == CHAR_NL) begin
      flush_line();
    end else begin
      if (shown) begin
        if (wrap_on && buf_count > 0 && int'(line_px) + int'(glyph_w) > int'(box_w)) flush_line();
        if (buf_count < LINE_CHARS) begin
          line_buf[buf_count] = c - first_code;
          buf_count++;
          line_px = line_px + 16'(glyph_w) + 16'(spacing);
        end else begin
          dropped = 1'b1;
        end
      end
      if (fin) flush_line();
    end
    if (step_glyphs.size() > 0) begin
      g = step_glyphs.pop_back();
      g.line_last = 1'b1;
      step_glyphs.push_back(g);
    end
    return (c == CHAR_NL) || fin || shown;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, $signed(want), $signed(got));
      errors++;
    end
  endfunction

  function automatic plan_row_t text_row(logic [7:0] code, logic fin, int glyphs = -1,
                                         logic [7:0] idx = '0, logic [15:0] x = '0,
                                         logic [15:0] y = '0);
    plan_row_t r;
    r.is_reg = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.code = code;
    r.fin = fin;
    r.glyphs = glyphs;
    r.idx = idx;
    r.x = x;
    r.y = y;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = text_row('0, 1'b0);
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic [7:0] pick_visible();
    logic [7:0] stop;
    stop = first_code + code_count;
    if (stop > first_code) return first_code + 8'($urandom_range(0, int'(code_count) - 1));
    return 8'($urandom);
  endfunction

  task automatic offer_text(input logic [7:0] c, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        text_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    text_ch.valid <= 1'b1;
    text_ch.data <= tlwa_in_t'{char_code: c, text_end: fin};
    do @(posedge clk); while (!text_ch.ready);
    burst_left--;
    bytes_sent++;
    if (place_text(c, fin)) text_items++;
    foreach (step_glyphs[i]) pending_glyphs.push_back(step_glyphs[i]);
  endtask

  // block idle: no request offered, nothing outstanding, pipeline drained
  task automatic settle();
    text_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_we high, the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_BOX_WIDTH: box_w = val;
      REG_GLYPH_WIDTH: glyph_w = val[7:0];
      REG_CHAR_SPACING: spacing = val[7:0];
      REG_LINE_ADVANCE: advance = val[8:0];
      REG_FIRST_CODE: first_code = val[7:0];
      REG_CODE_COUNT: code_count = val[7:0];
      REG_WRAP_ENABLE: wrap_on = val[0];
      REG_ALIGN_MODE: align = val[1:0];
      default: ;
    endcase
  endtask

  task automatic pick_config(input int phase);
    logic [11:0] bw;
    logic [7:0] gw;
    logic [7:0] sp;
    logic [8:0] adv;
    logic [7:0] fc;
    logic [7:0] cc;
    logic wr;
    logic [1:0] al;
    case (phase % 5)
      0: begin
        bw = '0; gw = 8'd1; sp = '0; adv = '0; fc = '0; cc = 8'd255;
        wr = 1'($urandom); al = 2'($urandom);
      end
      1: begin
        bw = 12'hFFF; gw = 8'hFF; sp = 8'hFF; adv = 9'h1FF; fc = 8'd32; cc = 8'd95;
        wr = 1'b1; al = ALIGN_RIGHT;
      end
      default: begin
        bw = $urandom_range(0, 1) ? 12'($urandom_range(0, 200)) : 12'($urandom);
        gw = 8'($urandom_range(1, 8));
        sp = 8'($urandom_range(0, 3));
        adv = 9'($urandom);
        fc = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 120));
        cc = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 150));
        wr = 1'($urandom);
        al = 2'($urandom);
      end
    endcase
    // spare upper bits should be dropped by the block
    write_reg(REG_BOX_WIDTH, bw);
    write_reg(REG_GLYPH_WIDTH, {4'($urandom), gw});
    write_reg(REG_CHAR_SPACING, {4'($urandom), sp});
    write_reg(REG_LINE_ADVANCE, {3'($urandom), adv});
    write_reg(REG_FIRST_CODE, {4'($urandom), fc});
    write_reg(REG_CODE_COUNT, {4'($urandom), cc});
    write_reg(REG_WRAP_ENABLE, {11'($urandom), wr});
    write_reg(REG_ALIGN_MODE, {10'($urandom), al});
    write_reg(REG_NONE + 4'($urandom_range(0, 7)), 12'($urandom));
    settings++;
  endtask

  task automatic send_sequence();
    int kind;
    int len;
    int i;
    bit fin_on_last;
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      len = (kind < 6) ? $urandom_range(0, 24) : $urandom_range(33, 40);
      fin_on_last = (kind < 6) && (len > 0) && ($urandom_range(0, 2) == 0);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0)
          offer_text($urandom_range(0, 1) ? CHAR_CR : 8'($urandom), 1'b0);
        offer_text(pick_visible(), fin_on_last && (i == len - 1));
      end
      if (!fin_on_last) offer_text(CHAR_NL, 1'($urandom_range(0, 3) == 0));
    end else begin
      repeat ($urandom_range(1, 6)) offer_text(8'($urandom), 1'($urandom_range(0, 7) == 0));
    end
  endtask

  // glyph sink: stall pattern plus one long hold-off on request
  initial begin
    flow_t flow;
    int seg;
    bit hold_done;
    glyph_ch.ready <= 1'b0;
    flow = FLOW_FREE;
    seg = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        glyph_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1;
      end else begin
        if (seg == 0) begin
          seg = $urandom_range(8, 80);
          flow = flow_t'($urandom_range(0, 3));
        end
        seg--;
        case (flow)
          FLOW_FREE: glyph_ch.ready <= 1'b1;
          FLOW_HALF: glyph_ch.ready <= 1'($urandom);
          FLOW_SPARSE: glyph_ch.ready <= ($urandom_range(0, 3) == 0);
          default: glyph_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    tlwa_out_t want;
    tlwa_out_t got;
    if (!rst && glyph_ch.valid && glyph_ch.ready) begin
      got = glyph_ch.data;
      if (pending_glyphs.size() == 0) begin
        $display("%0t: glyph with none expected, actual idx %0d x %0d y %0d", $time,
                 got.glyph_index, got.x_offset, got.y_offset);
        errors++;
      end else begin
        want = pending_glyphs.pop_front();
        check_field("glyph index", 16'(want.glyph_index), 16'(got.glyph_index));
        check_field("x offset", want.x_offset, got.x_offset);
        check_field("y offset", want.y_offset, got.y_offset);
        check_field("line last", 16'(want.line_last), 16'(got.line_last));
        check_field("chars dropped", 16'(want.chars_dropped), 16'(got.chars_dropped));
        glyphs_checked++;
        if (want.line_last) lines_seen++;
        if (want.chars_dropped) dropped_seen++;
      end
    end
  end

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: run timed out after %0d cycles", $time, cycles);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    plan_row_t row;
    bit cfg_open;
    int phase;
    int mark;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    text_ch.valid <= 1'b0;
    text_ch.data <= '0;
    reset_model();

    // reset values, skipped codes, newline and end mark cases
    plan.push_back(text_row(8'h41, 1'b0, 0));
    plan.push_back(text_row(CHAR_CR, 1'b0, 0));
    plan.push_back(text_row(8'h00, 1'b0, 0));
    plan.push_back(text_row(8'hFF, 1'b0, 0));
    plan.push_back(text_row(8'h7F, 1'b0, 0));
    plan.push_back(text_row(8'h7E, 1'b0, 0));
    plan.push_back(text_row(CHAR_NL, 1'b0, 2, 8'd33, 16'd0, 16'd0));
    plan.push_back(text_row(CHAR_NL, 1'b0, 0));
    plan.push_back(text_row(8'h20, 1'b1, 1, 8'd0, 16'd0, 16'd16));
    plan.push_back(text_row(CHAR_NL, 1'b1, 0));
    plan.push_back(text_row(CHAR_CR, 1'b1, 0));
    // wrap and end mark on one byte
    plan.push_back(reg_row(REG_BOX_WIDTH, 12'd12));
    plan.push_back(text_row(8'h61, 1'b0));
    plan.push_back(text_row(8'h62, 1'b0));
    plan.push_back(text_row(8'h63, 1'b1, 3, 8'd65, 16'd0, 16'd40));
    // alignment, negative centre offset, spare mode
    plan.push_back(reg_row(REG_ALIGN_MODE, 12'(ALIGN_CENTER)));
    plan.push_back(text_row(8'h61, 1'b0));
    plan.push_back(text_row(CHAR_NL, 1'b0, 1, 8'd65, 16'd3, 16'd56));
    plan.push_back(reg_row(REG_BOX_WIDTH, 12'd0));
    plan.push_back(reg_row(REG_WRAP_ENABLE, 12'd0));
    plan.push_back(text_row(8'h61, 1'b0));
    plan.push_back(text_row(8'h62, 1'b0));
    plan.push_back(text_row(CHAR_NL, 1'b0, 2, 8'd65, -16'sd5, 16'd64));
    plan.push_back(reg_row(REG_ALIGN_MODE, 12'(ALIGN_RIGHT)));
    plan.push_back(text_row(8'h61, 1'b0));
    plan.push_back(text_row(CHAR_NL, 1'b0, 1, 8'd65, -16'sd5, 16'd72));
    plan.push_back(reg_row(REG_ALIGN_MODE, 12'(ALIGN_SPARE)));
    plan.push_back(text_row(8'h61, 1'b1, 1, 8'd65, 16'd0, 16'd80));
    // top of most register ranges (not first code or align mode), upper bits masked, spare index ignored
    plan.push_back(reg_row(REG_BOX_WIDTH, 12'hFFF));
    plan.push_back(reg_row(REG_GLYPH_WIDTH, 12'hFFF));
    plan.push_back(reg_row(REG_CHAR_SPACING, 12'hFFF));
    plan.push_back(reg_row(REG_LINE_ADVANCE, 12'hFFF));
    plan.push_back(reg_row(REG_FIRST_CODE, 12'h000));
    plan.push_back(reg_row(REG_CODE_COUNT, 12'hFFF));
    plan.push_back(reg_row(REG_WRAP_ENABLE, 12'hFFF));
    plan.push_back(reg_row(REG_ALIGN_MODE, 12'hFFE));
    plan.push_back(reg_row(REG_NONE, 12'h000));
    plan.push_back(text_row(8'hFF, 1'b0, 0));
    plan.push_back(text_row(8'hFE, 1'b1, 1, 8'd254, 16'd3840, 16'd88));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cfg_open = 0;
    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_reg) begin
        if (!cfg_open) settle();
        write_reg(row.reg_idx, row.reg_val);
        cfg_open = 1;
      end else begin
        if (cfg_open) begin
          cfg_we <= 1'b0;
          cfg_open = 0;
        end
        offer_text(row.code, row.fin);
        if (row.glyphs >= 0) begin
          if (step_glyphs.size() != row.glyphs) begin
            $display("%0t: glyph count expected %0d actual %0d", $time, row.glyphs,
                     step_glyphs.size());
            errors++;
          end else if (row.glyphs > 0) begin
            check_field("directed glyph index", 16'(row.idx), 16'(step_glyphs[0].glyph_index));
            check_field("directed x offset", row.x, step_glyphs[0].x_offset);
            check_field("directed y offset", row.y, step_glyphs[0].y_offset);
          end
        end
      end
    end

    phase = 0;
    while (bytes_sent < TEXT_TARGET) begin
      settle();
      pick_config(phase);
      cfg_we <= 1'b0;
      if (phase == 1) hold_req = 1;
      mark = bytes_sent;
      while (bytes_sent - mark < PHASE_TEXT && bytes_sent < TEXT_TARGET) send_sequence();
      phase++;
    end

    text_ch.valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d text bytes (%0d placed or ending a line) over %0d register settings",
             bytes_sent, text_items, settings);
    $display("checked %0d glyphs in %0d lines with a long sink hold-off, %0d flagged as dropped",
             glyphs_checked, lines_seen, dropped_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/tlwa_pkg.sv
hw/rtl/tlwa_chan_if.sv
hw/rtl/text_line_wrap_align.sv
bench/tb_text_line_wrap_align.sv
